// ===== design/bqf_pkg.sv =====
`default_nettype none

package bqf_pkg;

  // Coefficient registers are Q4.20 style signed words of fixed width.
  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  // Configuration register indexes, also used as coefficient selects.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREGAIN = 3'd0,
    REG_FF0     = 3'd1,
    REG_FF1     = 3'd2,
    REG_FF2     = 3'd3,
    REG_FB1     = 3'd4,
    REG_FB2     = 3'd5
  } reg_idx_t;

  // Sample operand of the multiplier.
  typedef enum logic [2:0] {
    SMP_IN,
    SMP_S0,
    SMP_S1,
    SMP_S2,
    SMP_Y1,
    SMP_Y2
  } smp_sel_t;

  // Accumulator operation on the registered product.
  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Use of the shared round/saturate unit.
  typedef enum logic [1:0] {
    RND_NONE,
    RND_PRE,
    RND_OUT
  } rnd_op_t;

  // Sequencing of a step.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT
  } seq_op_t;

  typedef logic [STEP_W-1:0] step_t;

  // One control word.
  typedef struct packed {
    reg_idx_t coef_sel;
    smp_sel_t smp_sel;
    acc_op_t  acc_op;
    rnd_op_t  rnd_op;
    seq_op_t  seq_op;
    step_t    target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    ucode_t uc;
    logic   fire;
  } ctl_t;

  localparam step_t STEP_IDLE = 3'd0;

  // Microprogram. The product register is loaded in every step, so the
  // accumulator works one step behind the multiplier.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = '{coef_sel: REG_PREGAIN, smp_sel: SMP_IN, acc_op: ACC_NOP,
           rnd_op: RND_NONE, seq_op: SEQ_NEXT, target: STEP_IDLE};
    case (step)
      3'd0: begin
        // Wait for a sample; pregain times input is formed at the transfer.
        uc.seq_op = SEQ_WAIT_IN;
      end
      3'd1: begin
        uc.coef_sel = REG_FF1;
        uc.smp_sel  = SMP_S1;
        uc.rnd_op   = RND_PRE;
      end
      3'd2: begin
        uc.coef_sel = REG_FF0;
        uc.smp_sel  = SMP_S0;
        uc.acc_op   = ACC_LOAD;
      end
      3'd3: begin
        uc.coef_sel = REG_FF2;
        uc.smp_sel  = SMP_S2;
        uc.acc_op   = ACC_ADD;
      end
      3'd4: begin
        uc.coef_sel = REG_FB1;
        uc.smp_sel  = SMP_Y1;
        uc.acc_op   = ACC_ADD;
      end
      3'd5: begin
        uc.coef_sel = REG_FB2;
        uc.smp_sel  = SMP_Y2;
        uc.acc_op   = ACC_SUB;
      end
      3'd6: begin
        uc.acc_op = ACC_SUB;
      end
      3'd7: begin
        // Round the sum into the output register once it is free.
        uc.rnd_op = RND_OUT;
        uc.seq_op = SEQ_WAIT_OUT;
        uc.target = STEP_IDLE;
      end
      default: begin
        uc.seq_op = SEQ_WAIT_IN;
      end
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

// ===== design/bqf_rndsat.sv =====
`default_nettype none

module bqf_rndsat #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20,
  parameter int ACC_W          = 43
) (
  input  wire logic signed [ACC_W-1:0]       val,
  output logic signed      [SAMPLE_BITS-1:0] res,
  output logic                               clip
);

  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [ACC_W-1:0]          sum;
  logic signed [ACC_W-1:0]          shifted;
  logic [ACC_W-SAMPLE_BITS:0]       top;

  // Round to nearest with ties upward, then drop the fraction bits.
  assign sum     = val + $signed(HALF);
  assign shifted = sum >>> COEF_FRAC_BITS;
  assign top     = shifted[ACC_W-1:SAMPLE_BITS-1];

  // The value fits when all bits from the sample sign up agree.
  always_comb begin
    clip = !((&top) || !(|top));
    if (!clip) begin
      res = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[ACC_W-1]) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== design/bqf_sequencer.sv =====
`default_nettype none

module bqf_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output bqf_pkg::ctl_t    ctl
);

  import bqf_pkg::*;

  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;
  ucode_t uc;
  logic   fire;

  assign uc = ucode_rom(step_r);

  // A step completes when its wait condition is met.
  always_comb begin
    unique case (uc.seq_op)
      SEQ_NEXT:     fire = 1'b1;
      SEQ_WAIT_IN:  fire = in_tvalid;
      SEQ_WAIT_OUT: fire = !out_valid_r || out_tready;
      default:      fire = 1'b0;
    endcase
  end

  // Step counter with a jump on the waiting steps.
  always_comb begin
    step_nxt = step_r;
    if (fire) begin
      if (uc.seq_op == SEQ_WAIT_OUT) begin
        step_nxt = uc.target;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  // The output register fills on the last step and empties on a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && uc.rnd_op == RND_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (uc.seq_op == SEQ_WAIT_IN);
  assign out_tvalid = out_valid_r;
  assign ctl.uc     = uc;
  assign ctl.fire   = fire;

endmodule

`default_nettype wire

// ===== design/bqf_datapath.sv =====
`default_nettype none

module bqf_datapath #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire bqf_pkg::ctl_t                         ctl,
  input  wire logic                                  cfg_we,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  wire logic [bqf_pkg::COEF_W-1:0]            cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
  output logic signed [SAMPLE_BITS-1:0]              sample_out,
  output logic                                       clipped
);

  import bqf_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic [COEF_W-1:0] COEF_ONE =
    (COEF_FRAC_BITS >= COEF_W - 1) ? {1'b0, {(COEF_W-1){1'b1}}}
                                   : COEF_W'(1) << COEF_FRAC_BITS;

  // Coefficient registers.
  logic signed [COEF_W-1:0] pregain_r, ff0_r, ff1_r, ff2_r, fb1_r, fb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pregain_r <= COEF_ONE;
      ff0_r     <= COEF_ONE;
      ff1_r     <= '0;
      ff2_r     <= '0;
      fb1_r     <= '0;
      fb2_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PREGAIN: pregain_r <= cfg_wdata;
        REG_FF0:     ff0_r     <= cfg_wdata;
        REG_FF1:     ff1_r     <= cfg_wdata;
        REG_FF2:     ff2_r     <= cfg_wdata;
        REG_FB1:     fb1_r     <= cfg_wdata;
        REG_FB2:     fb2_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sample history and the current scaled input.
  logic signed [SAMPLE_BITS-1:0] s0_r, s1_r, s2_r, y1_r, y2_r;
  logic                          clip_r;

  // Operand selection and the shared multiplier.
  logic signed [COEF_W-1:0]      coef;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [PROD_W-1:0]      prod_r;

  always_comb begin
    unique case (ctl.uc.coef_sel)
      REG_PREGAIN: coef = pregain_r;
      REG_FF0:     coef = ff0_r;
      REG_FF1:     coef = ff1_r;
      REG_FF2:     coef = ff2_r;
      REG_FB1:     coef = fb1_r;
      REG_FB2:     coef = fb2_r;
      default:     coef = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.uc.smp_sel)
      SMP_IN:  smp = sample_in;
      SMP_S0:  smp = s0_r;
      SMP_S1:  smp = s1_r;
      SMP_S2:  smp = s2_r;
      SMP_Y1:  smp = y1_r;
      SMP_Y2:  smp = y2_r;
      default: smp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * smp;
  end

  // Accumulator, one step behind the multiplier.
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] prod_ext;

  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.fire) begin
      case (ctl.uc.acc_op)
        ACC_LOAD: acc_nxt = prod_ext;
        ACC_ADD:  acc_nxt = acc_r + prod_ext;
        ACC_SUB:  acc_nxt = acc_r - prod_ext;
        default:  acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Shared round/saturate unit, fed by the product for the pregain stage
  // and by the accumulator for the output stage.
  logic signed [ACC_W-1:0]       rnd_in;
  logic signed [SAMPLE_BITS-1:0] rnd_res;
  logic                          rnd_clip;

  assign rnd_in = (ctl.uc.rnd_op == RND_PRE) ? prod_ext : acc_r;

  bqf_rndsat #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_W          (ACC_W)
  ) u_rndsat (
    .val  (rnd_in),
    .res  (rnd_res),
    .clip (rnd_clip)
  );

  // Scaled input and the clip flag of the pregain stage.
  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.uc.rnd_op == RND_PRE) begin
      s0_r   <= rnd_res;
      clip_r <= rnd_clip;
    end
  end

  // History shifts when a result is written out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (ctl.fire && ctl.uc.rnd_op == RND_OUT) begin
      s2_r <= s1_r;
      s1_r <= s0_r;
      y2_r <= y1_r;
      y1_r <= rnd_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.uc.rnd_op == RND_OUT) begin
      sample_out <= rnd_res;
      clipped    <= clip_r || rnd_clip;
    end
  end

endmodule

`default_nettype wire

// ===== design/biquad_filter_with_pregain_core.sv =====
// An input transfer's result is loaded into the output register at the last step,
// or later while that register still holds an earlier result.
// Samples are processed one at a time by the single shared multiplier
// that runs the six products of the microprogram one step apart.
// A new sample is taken while an earlier result still waits for its transfer.
// Reset (rst_n low, synchronous) clears the history, loads pregain and ff0
// with one and all other coefficients with zero.
`default_nettype none

module biquad_filter_with_pregain_core #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata: sample_in
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: sample_out, clipped
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]       out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [bqf_pkg::COEF_W-1:0]        cfg_wdata
);

  import bqf_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

  ctl_t                          ctl;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  bqf_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  bqf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .sample_in  (in_tdata[SAMPLE_BITS-1:0]),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  // Pack the result fields, padded to whole bytes.
  assign out_tdata = OUT_W'({clipped, sample_out});

  // Only one sample is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a sample was still in work");

  // A result that appears in an empty output register is loaded at the last step of
  // the microprogram that its sample transfer started, with no wait in between.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 8))
    else $error("result appeared without a matching input transfer");

endmodule

`default_nettype wire

// ===== tb/tb_biquad_filter_with_pregain_core.sv =====
`default_nettype none

module tb_biquad_filter_with_pregain_core;
  import bqf_pkg::*;

  localparam int SMP_W     = 16;
  localparam int FRAC_BITS = 20;
  localparam longint SMP_MAX = 32767;
  localparam longint SMP_MIN = -32768;

  // Register addresses past the last coefficient; writes there do nothing.
  localparam logic [CFG_IDX_W-1:0] ADDR_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] ADDR_SPARE_B = 3'd7;

  typedef enum int {CS_FULL, CS_MILD, CS_EDGE} coef_style_e;
  typedef enum int {SS_FULL, SS_QUIET, SS_EDGE} smp_style_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic             clip;
    logic [SMP_W-1:0] level;
  } filt_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [15:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  wire  [23:0] out_tdata;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  biquad_filter_with_pregain_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),    // sample_in
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),   // sample_out, clipped
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Samples waiting to be sent and filter outputs waiting to arrive.
  logic [SMP_W-1:0] pending_q[$];
  filt_out_t        expected_q[$];

  // Shadow copy of the coefficients and the filter history.
  longint coef_q [0:5];
  longint hist_s1, hist_s2, hist_y1, hist_y2;

  int fault_count = 0;
  int burst_left, gap_left;
  int choke_req = 0;
  int choke_seen = 0;
  int choke_left = 0;
  int mode_left = 0;
  int rx_tick = 0;
  rx_mode_e rx_mode = RX_OPEN;

  initial begin
    forever #5 clk = ~clk;
  end

  // Round to nearest with ties toward plus infinity, then drop the fraction.
  function automatic longint q20_round(input longint acc);
    return (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_sample(input longint r);
    if (r > SMP_MAX) return SMP_MAX;
    if (r < SMP_MIN) return SMP_MIN;
    return r;
  endfunction

  // Computes one filter output and advances the history.
  function automatic filt_out_t filter_step(input logic [SMP_W-1:0] raw);
    longint x, r, s0, acc, y0;
    filt_out_t res;
    x = longint'($signed(raw));
    r = q20_round(coef_q[REG_PREGAIN] * x);
    s0 = clamp_sample(r);
    res.clip = (s0 != r);
    acc = coef_q[REG_FF0] * s0 + coef_q[REG_FF1] * hist_s1 + coef_q[REG_FF2] * hist_s2
        - coef_q[REG_FB1] * hist_y1 - coef_q[REG_FB2] * hist_y2;
    r = q20_round(acc);
    y0 = clamp_sample(r);
    if (y0 != r) res.clip = 1'b1;
    res.level = y0[SMP_W-1:0];
    hist_s2 = hist_s1;
    hist_s1 = s0;
    hist_y2 = hist_y1;
    hist_y1 = y0;
    return res;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(input coef_style_e style);
    case (style)
      CS_MILD: return COEF_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
      CS_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 24'h7fffff;
          1: return 24'h800000;
          2: return 24'h100000;
          default: return 24'h000000;
        endcase
      end
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample(input smp_style_e style);
    case (style)
      SS_QUIET: return SMP_W'($urandom_range(0, 511) - 256);
      SS_EDGE: begin
        case ($urandom_range(0, 4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return SMP_W'($urandom);
        endcase
      end
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Writes one register while the filter is idle and mirrors it.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] addr, input logic [COEF_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr <= REG_FB2) coef_q[addr] = longint'($signed(value));
  endtask

  task automatic queue_samples(input logic [SMP_W-1:0] vals[]);
    @(negedge clk);
    foreach (vals[i]) pending_q.push_back(vals[i]);
  endtask

  // Waits until every sample is sent and every output has arrived.
  task automatic wait_idle();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_tvalid) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Sender: bursts of random length with random gaps in between.
  always @(posedge clk) begin : send_proc
    logic next_valid;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left = 4;
      gap_left   = 0;
    end else begin
      next_valid = 1'b0;
      if (in_tvalid && in_tready) begin
        expected_q.push_back(filter_step(pending_q.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        next_valid = 1'b1;
        in_tdata <= pending_q[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Receiver: changes its stall pattern now and then; a choke request holds it off.
  always @(posedge clk) begin : recv_proc
    logic ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (choke_req != choke_seen) begin
        choke_seen = choke_req;
        choke_left = 240;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (choke_left > 0) begin
        choke_left--;
        ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:     ready = 1'b1;
          RX_COIN:     ready = $urandom_range(0, 1);
          RX_SPARSE:   ready = ($urandom_range(0, 3) == 0);
          default:     ready = ((rx_tick % 5) < 2);
        endcase
      end
      out_tready <= ready;
    end
  end

  // Checks each output transfer against the oldest expected value.
  always @(posedge clk) begin : check_proc
    filt_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected output transfer: sample_out=%h clipped=%b",
                   out_tdata[15:0], out_tdata[16]);
        fault_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[15:0] !== want.level || out_tdata[16] !== want.clip) begin
          if (fault_count < 10)
            $display("mismatch: sample_out exp %h got %h, clipped exp %b got %b",
                     want.level, out_tdata[15:0], want.clip, out_tdata[16]);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stim
    logic [SMP_W-1:0] vals[];
    int n;
    smp_style_e sstyle;

    coef_q[REG_PREGAIN] = 64'sd1 <<< FRAC_BITS;
    coef_q[REG_FF0]     = 64'sd1 <<< FRAC_BITS;
    coef_q[REG_FF1]     = 0;
    coef_q[REG_FF2]     = 0;
    coef_q[REG_FB1]     = 0;
    coef_q[REG_FB2]     = 0;
    hist_s1 = 0;
    hist_s2 = 0;
    hist_y1 = 0;
    hist_y2 = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Unity gain straight through, with the extremes of the input.
    queue_samples('{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h5555, 16'haaaa});
    wait_idle();

    // Largest pregain: the input stage saturates.
    write_coef(REG_PREGAIN, 24'h7fffff);
    queue_samples('{16'h7fff, 16'h8000, 16'h1234, 16'h0000});
    wait_idle();

    // Half gain: exact ties round toward plus infinity.
    write_coef(REG_PREGAIN, 24'h080000);
    queue_samples('{16'h0001, 16'hffff, 16'h0003, 16'hfffd});
    wait_idle();

    // Most negative pregain flips the most negative sample past full scale.
    write_coef(REG_PREGAIN, 24'h800000);
    queue_samples('{16'h8000, 16'h7fff});
    wait_idle();

    // Extreme taps drive the output stage into saturation; spare addresses are ignored.
    write_coef(REG_PREGAIN, 24'h100000);
    write_coef(REG_FF0, 24'h7fffff);
    write_coef(REG_FF1, 24'h800000);
    write_coef(REG_FF2, 24'h7fffff);
    write_coef(REG_FB1, 24'h800000);
    write_coef(REG_FB2, 24'h7fffff);
    write_coef(ADDR_SPARE_A, 24'h123456);
    write_coef(ADDR_SPARE_B, 24'h800000);
    queue_samples('{16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h0000, 16'h0000});
    wait_idle();

    // Random coefficient sets, each followed by a run of random samples.
    for (int phase = 0; phase < 16; phase++) begin
      for (int r = REG_PREGAIN; r <= REG_FB2; r++)
        write_coef(CFG_IDX_W'(r), pick_coef(coef_style_e'($urandom_range(0, 2))));
      if ($urandom_range(0, 4) == 0) write_coef(ADDR_SPARE_A, COEF_W'($urandom));
      sstyle = smp_style_e'($urandom_range(0, 2));
      n = $urandom_range(35, 65);
      vals = new[n];
      foreach (vals[i])
        vals[i] = pick_sample(($urandom_range(0, 3) == 0) ? SS_FULL : sstyle);
      queue_samples(vals);
      // Hold the receiver off for a long stretch so the input side backs up.
      if (phase == 2 || phase == 9) choke_req = choke_req + 1;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/bqf_pkg.sv
design/bqf_rndsat.sv
design/bqf_sequencer.sv
design/bqf_datapath.sv
design/biquad_filter_with_pregain_core.sv
tb/tb_biquad_filter_with_pregain_core.sv
